@@ hdl/mtee_pkg.sv @@
// package: shared types and constants for the midi track event encoder
`default_nettype none
package mtee_pkg;

  // status and kind codes
  localparam logic [7:0] NoStatus    = 8'hFF;
  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [3:0] KindNoteOff = 4'h8;
  localparam logic [3:0] KindNoteOn  = 4'h9;
  localparam logic [3:0] KindPoly    = 4'hA;
  localparam logic [3:0] KindCtrl    = 4'hB;
  localparam logic [3:0] KindBend    = 4'hE;
  localparam logic [3:0] KindSystem  = 4'hF;
  localparam logic [4:0] KeepChannel = 5'd16;
  localparam logic [7:0] VlqMore     = 8'h80;

  // queue depth between front and back
  localparam int QueueDepthDefault = 2;

  // one classified event, ready for byte emission
  typedef struct packed {
    logic [27:0] delta;     // raw delta ticks
    logic [1:0]  vlq_len;   // number of delta bytes minus one
    logic        send_st;   // status byte is emitted
    logic [7:0]  st;        // status byte, after override and note-off rewrite except for system kinds
    logic [7:0]  d1;
    logic        send_d2;   // second data byte is emitted
    logic [7:0]  d2;
  } event_desc_t;

endpackage
`default_nettype wire

@@ hdl/midi_track_event_encoder_top.sv @@
// Encodes MIDI channel events into Standard MIDI File track bytes.
// Input channel: one event word per handshake (in_valid / in_ready) with delta
// ticks, status, two data bytes, a channel override and a new-track flag.
// Output channel: one byte word per handshake (out_valid / out_ready), with
// out_last_byte set on the final byte of each event.
// Each event yields 2 to 7 bytes: 1 to 4 delta bytes, the status byte unless
// running status drops it, the first data byte and, for two-byte kinds, the
// second one. The back end emits one byte per cycle while out_ready is high, so
// an event's byte count sets the sustained rate. When the queue is empty, an
// accepted event is written into the queue and its first byte then passes
// through the output register before it is presented with out_valid. The front
// end accepts a new event every cycle while the event queue has room,
// independent of the back end. When the receiver stalls, the output byte holds
// and the queue fills; once full, in_ready drops. Reset empties the queue,
// clears out_valid and sets running status to none.
`default_nettype none
module midi_track_event_encoder_top
  import mtee_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [27:0] in_delta_ticks,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [7:0]  in_first_data,
  input  wire logic [7:0]  in_second_data,
  input  wire logic [4:0]  in_channel_override,
  input  wire logic        in_new_track,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  logic        q_full, q_empty, q_push, q_pop;
  event_desc_t push_desc, head_desc;

  // front end
  mtee_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_delta_ticks      (in_delta_ticks),
    .in_status_byte      (in_status_byte),
    .in_first_data       (in_first_data),
    .in_second_data      (in_second_data),
    .in_channel_override (in_channel_override),
    .in_new_track        (in_new_track),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_desc              (push_desc)
  );

  // event queue
  mtee_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_desc (head_desc)
  );

  // back end
  mtee_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_desc        (head_desc),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
`default_nettype wire

@@ hdl/mtee_front.sv @@
// front end: accepts events, applies running status and classifies them
`default_nettype none
module mtee_front
  import mtee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [27:0] in_delta_ticks,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [7:0]  in_first_data,
  input  wire logic [7:0]  in_second_data,
  input  wire logic [4:0]  in_channel_override,
  input  wire logic        in_new_track,
  input  wire logic        q_full,
  output logic             q_push,
  output event_desc_t      q_desc
);

  logic [7:0] run_st_r, run_st_nxt;
  logic [7:0] rs_cur;
  logic [7:0] st_raw, st_ovr, st_fin;
  logic [7:0] d2_fin;
  logic       is_system;
  logic [3:0] kind_fin;
  logic [1:0] vlq_len;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // status rewrite and running status decision
  always_comb begin
    st_raw    = in_status_byte | StatusBit;
    is_system = (st_raw[7:4] == KindSystem);
    rs_cur    = in_new_track ? NoStatus : run_st_r;
    st_ovr    = (in_channel_override < KeepChannel) ?
                {st_raw[7:4], in_channel_override[3:0]} : st_raw;
    st_fin    = st_ovr;
    d2_fin    = in_second_data;
    if (st_ovr[7:4] == KindNoteOff) begin
      st_fin = {KindNoteOn, st_ovr[3:0]};
      d2_fin = 8'h00;
    end
    kind_fin = st_fin[7:4];
    q_desc.delta   = in_delta_ticks;
    q_desc.vlq_len = vlq_len;
    q_desc.d1      = in_first_data;
    q_desc.d2      = d2_fin;
    if (is_system) begin
      q_desc.st      = st_raw;
      q_desc.send_st = 1'b1;
      q_desc.send_d2 = 1'b0;
      run_st_nxt     = NoStatus;
    end else begin
      q_desc.st      = st_fin;
      q_desc.send_st = (st_fin != rs_cur);
      q_desc.send_d2 = (kind_fin == KindNoteOn) || (kind_fin == KindPoly) ||
                       (kind_fin == KindCtrl) || (kind_fin == KindBend);
      run_st_nxt     = st_fin;
    end
  end

  // delta length in 7-bit groups
  always_comb begin
    if (in_delta_ticks[27:21] != 7'd0) begin
      vlq_len = 2'd3;
    end else if (in_delta_ticks[20:14] != 7'd0) begin
      vlq_len = 2'd2;
    end else if (in_delta_ticks[13:7] != 7'd0) begin
      vlq_len = 2'd1;
    end else begin
      vlq_len = 2'd0;
    end
  end

  // running status register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_st_r <= NoStatus;
    end else if (q_push) begin
      run_st_r <= run_st_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mtee_queue.sv @@
// small fifo of classified events between front and back
`default_nettype none
module mtee_queue
  import mtee_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  event_desc_t      push_desc,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output event_desc_t      head_desc
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  event_desc_t     mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == FullCnt);
  assign empty     = (count_r == '0);
  assign head_desc = mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a word");

endmodule
`default_nettype wire

@@ hdl/mtee_back.sv @@
// back end: walks one event and emits its bytes through an output register
`default_nettype none
module mtee_back
  import mtee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  event_desc_t      q_desc,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic [2:0] vlen, total, rel;
  logic [1:0] grp_idx;
  logic [6:0] grp;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign load = (!out_valid_r || out_ready) && !q_empty;

  // byte selection for the current step
  always_comb begin
    vlen     = {1'b0, q_desc.vlq_len} + 3'd1;
    total    = vlen + {2'b0, q_desc.send_st} + 3'd1 + {2'b0, q_desc.send_d2};
    grp_idx  = q_desc.vlq_len - step_r[1:0];
    rel      = step_r - vlen;
    case (grp_idx)
      2'd0:    grp = q_desc.delta[6:0];
      2'd1:    grp = q_desc.delta[13:7];
      2'd2:    grp = q_desc.delta[20:14];
      2'd3:    grp = q_desc.delta[27:21];
      default: grp = q_desc.delta[6:0];
    endcase
    if (step_r < vlen) begin
      cur_byte = {1'b0, grp} | ((grp_idx != 2'd0) ? VlqMore : 8'h00);
    end else if (q_desc.send_st) begin
      cur_byte = (rel == 3'd0) ? q_desc.st : ((rel == 3'd1) ? q_desc.d1 : q_desc.d2);
    end else begin
      cur_byte = (rel == 3'd0) ? q_desc.d1 : q_desc.d2;
    end
    cur_last = (step_r == total - 3'd1);
  end

  // step counter and output handshake
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (cur_last) begin
        step_nxt = 3'd0;
        q_pop    = 1'b1;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

  // checks
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (step_r < total)) else $error("byte step ran past the event");
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (step_r == 3'd0)) else $error("step not cleared after last byte");

endmodule
`default_nettype wire

@@ verif/midi_track_event_encoder_top_tb.sv @@
// testbench for the midi track event encoder: directed table, random events, byte checker
`timescale 1ns / 100ps
module midi_track_event_encoder_top_tb;
  import mtee_pkg::*;

  localparam int NumDirected = 23;
  localparam int NumRandom   = 207;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 20;
  localparam int MaxReports  = 40;

  // one input event plus an optional typed expectation (first byte in the top bits)
  typedef struct packed {
    logic [27:0] delta;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [4:0]  ovr;
    logic        fresh;
    logic [2:0]  exp_n;
    logic [55:0] exp_bytes;
  } event_word_t;

  // one byte of the encoded track stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [27:0] in_delta_ticks;
  logic [7:0]  in_status_byte;
  logic [7:0]  in_first_data;
  logic [7:0]  in_second_data;
  logic [4:0]  in_channel_override;
  logic        in_new_track;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_byte;

  event_word_t event_list [$];
  track_byte_t pending_bytes [$];
  logic [7:0]  last_sent_status;
  int          events_taken;
  int          error_count;

  // directed events: rows with exp_n of zero are checked against the predictor
  event_word_t directed_rows [NumDirected] = '{
    // first event after reset sends its status
    {28'h0000000, 8'h90, 8'h3C, 8'h64, 5'd16, 1'b0, 3'd4, 56'h00903C64000000},
    // same status again, one-byte delta at its top
    {28'h000007F, 8'h90, 8'h40, 8'h7F, 5'd16, 1'b0, 3'd3, 56'h7F407F00000000},
    // two-byte delta at its bottom, zero data
    {28'h0000080, 8'h90, 8'h00, 8'h00, 5'd16, 1'b0, 3'd4, 56'h81000000000000},
    // largest delta, note-off rewritten to note-on with zero velocity
    {28'hFFFFFFF, 8'h8F, 8'hFF, 8'hFF, 5'd16, 1'b0, 3'd7, 56'hFFFFFF7F9FFF00},
    {28'h0003FFF, 8'hA5, 8'h12, 8'h34, 5'd3,  1'b0, 3'd0, 56'h0},
    {28'h0004000, 8'hB0, 8'h07, 8'h7F, 5'd0,  1'b0, 3'd0, 56'h0},
    {28'h01FFFFF, 8'hC2, 8'h05, 8'hAA, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'h0200000, 8'hD2, 8'h40, 8'h55, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'h0000000, 8'hE0, 8'h00, 8'h40, 5'd15, 1'b0, 3'd0, 56'h0},
    // status without its top bit
    {28'h0000000, 8'h15, 8'h01, 8'h02, 5'd16, 1'b0, 3'd4, 56'h00950102000000},
    {28'h0000000, 8'h00, 8'h3C, 8'h7F, 5'd16, 1'b0, 3'd4, 56'h00903C00000000},
    // system status ignores the override and clears running status
    {28'h0000000, 8'hF0, 8'h22, 8'h33, 5'd5,  1'b0, 3'd3, 56'h00F02200000000},
    {28'h0000000, 8'h90, 8'h3C, 8'h64, 5'd16, 1'b0, 3'd4, 56'h00903C64000000},
    {28'h0000000, 8'h7F, 8'h11, 8'h22, 5'd0,  1'b0, 3'd3, 56'h00FF1100000000},
    // overrides above sixteen keep the channel
    {28'h0000005, 8'h93, 8'h40, 8'h50, 5'd31, 1'b0, 3'd0, 56'h0},
    {28'h0000005, 8'h93, 8'h41, 8'h51, 5'd17, 1'b0, 3'd0, 56'h0},
    // new track resends the same status
    {28'h0000005, 8'h93, 8'h42, 8'h52, 5'd16, 1'b1, 3'd0, 56'h0},
    {28'h0000001, 8'h85, 8'h43, 8'h60, 5'd2,  1'b0, 3'd0, 56'h0},
    {28'h0000001, 8'h92, 8'h44, 8'h70, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'h0000001, 8'h82, 8'h44, 8'h70, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'h0000000, 8'hF8, 8'h00, 8'h00, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'hFE00000, 8'hC0, 8'h7F, 8'h80, 5'd16, 1'b0, 3'd0, 56'h0},
    {28'h0000000, 8'hEF, 8'hFF, 8'hFF, 5'd0,  1'b0, 3'd0, 56'h0}
  };

  midi_track_event_encoder_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_delta_ticks      (in_delta_ticks),
    .in_status_byte      (in_status_byte),
    .in_first_data       (in_first_data),
    .in_second_data      (in_second_data),
    .in_channel_override (in_channel_override),
    .in_new_track        (in_new_track),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_last_byte       (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor: bytes of one event, updating the running status
  task automatic encode_event(input event_word_t ev);
    logic [7:0] seq [$];
    logic [7:0] st;
    logic [7:0] d2;
    logic [6:0] grp;
    logic       started;
    logic       system;
    track_byte_t tb;
    if (ev.fresh) last_sent_status = NoStatus;
    started = 1'b0;
    // delta as vlq, most significant group first
    for (int g = 3; g >= 0; g--) begin
      grp = ev.delta[7 * g +: 7];
      if (grp != 7'd0 || started || g == 0) begin
        started = 1'b1;
        seq.push_back({1'b0, grp} | ((g != 0) ? VlqMore : 8'h00));
      end
    end
    st = ev.status | StatusBit;
    d2 = ev.d2;
    system = (st[7:4] == KindSystem);
    if (!system) begin
      if (ev.ovr < KeepChannel) st[3:0] = ev.ovr[3:0];
      if (st[7:4] == KindNoteOff) begin
        st[7:4] = KindNoteOn;
        d2 = 8'h00;
      end
      if (st != last_sent_status) begin
        seq.push_back(st);
        last_sent_status = st;
      end
    end else begin
      seq.push_back(st);
      last_sent_status = NoStatus;
    end
    seq.push_back(ev.d1);
    if (!system && (st[7:4] == KindNoteOff || st[7:4] == KindNoteOn || st[7:4] == KindPoly ||
                    st[7:4] == KindCtrl || st[7:4] == KindBend))
      seq.push_back(d2);
    // typed rows replace the predicted bytes
    if (ev.exp_n != 3'd0) begin
      seq.delete();
      for (int i = 0; i < ev.exp_n; i++) seq.push_back(ev.exp_bytes[55 - 8 * i -: 8]);
    end
    foreach (seq[i]) begin
      tb.data = seq[i];
      tb.last = (i == seq.size() - 1);
      pending_bytes.push_back(tb);
    end
  endtask

  // accept monitor and byte checker
  always @(posedge clk) begin
    track_byte_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_event(event_list[events_taken]);
        events_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          if (error_count < MaxReports)
            $display("%0t: unexpected byte, expected none actual %02h last %0b",
                     $time, out_byte, out_last_byte);
          error_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.data) begin
            if (error_count < MaxReports)
              $display("%0t: out_byte mismatch, expected %02h actual %02h",
                       $time, want.data, out_byte);
            error_count++;
          end
          if (out_last_byte !== want.last) begin
            if (error_count < MaxReports)
              $display("%0t: out_last_byte mismatch, expected %0b actual %0b",
                       $time, want.last, out_last_byte);
            error_count++;
          end
        end
      end
    end
  end

  // receiver: stall patterns picked at random from four modes, one long hold-off
  initial begin
    int  cyc;
    int  mode;
    bit  held;
    out_ready = 1'b0;
    cyc = 0;
    mode = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && events_taken >= 40) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cyc % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
      cyc++;
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus build, reset, bursty sender, end of run
  initial begin
    event_word_t ev;
    logic [7:0]  prev_status;
    logic [4:0]  prev_ovr;
    int          pick;
    int          idx;
    int          burst_left;
    int          gap_left;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_delta_ticks = '0;
    in_status_byte = '0;
    in_first_data = '0;
    in_second_data = '0;
    in_channel_override = '0;
    in_new_track = 1'b0;
    last_sent_status = NoStatus;
    events_taken = 0;
    error_count = 0;
    prev_status = 8'h90;
    prev_ovr = KeepChannel;

    for (int i = 0; i < NumDirected; i++) event_list.push_back(directed_rows[i]);
    // random events, many repeating the last status to exercise running status
    for (int i = 0; i < NumRandom; i++) begin
      ev = '0;
      case ($urandom_range(0, 3))
        0: ev.delta = 28'($urandom_range(0, 127));
        1: ev.delta = 28'($urandom_range(128, 16383));
        2: ev.delta = 28'($urandom_range(16384, 2097151));
        default: ev.delta = 28'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 45) ev.status = prev_status;
      else if (pick < 85) ev.status = 8'($urandom_range(8'h80, 8'hEF));
      else ev.status = 8'($urandom_range(0, 255));
      ev.d1 = 8'($urandom);
      ev.d2 = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (ev.status == prev_status && pick < 80) ev.ovr = prev_ovr;
      else if (pick < 50) ev.ovr = KeepChannel;
      else if (pick < 88) ev.ovr = 5'($urandom_range(0, 15));
      else ev.ovr = 5'($urandom_range(17, 31));
      ev.fresh = ($urandom_range(0, 9) == 0);
      prev_status = ev.status;
      prev_ovr = ev.ovr;
      event_list.push_back(ev);
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    idx = 0;
    gap_left = 0;
    burst_left = $urandom_range(1, 10);
    while (idx < event_list.size()) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
        @(negedge clk);
      end else begin
        in_valid <= 1'b1;
        in_delta_ticks <= event_list[idx].delta;
        in_status_byte <= event_list[idx].status;
        in_first_data <= event_list[idx].d1;
        in_second_data <= event_list[idx].d2;
        in_channel_override <= event_list[idx].ovr;
        in_new_track <= event_list[idx].fresh;
        @(negedge clk);
        while (events_taken <= idx) @(negedge clk);
        idx++;
        burst_left--;
        if (burst_left == 0) begin
          gap_left = $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray bytes
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ midi_track_event_encoder_top.f @@
hdl/mtee_pkg.sv
hdl/mtee_front.sv
hdl/mtee_queue.sv
hdl/mtee_back.sv
hdl/midi_track_event_encoder_top.sv
verif/midi_track_event_encoder_top_tb.sv
